>>> hdl/hrq_pkg.sv
// hrq_pkg: shared constants, types and the threshold search function
// for the hysteresis range quantizer. No dependencies.
package hrq_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int THR_W           = 16;
	localparam int IDX_W           = 3;
	localparam int NUM_SLOTS       = 8;
	localparam int HALF_W          = 64;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int COUNT_W         = 4;
	localparam int TABLE_W         = THR_W * NUM_SLOTS;
	localparam int QUEUE_DEPTH     = 2;
	localparam int DEF_MAX_RANGES  = 8;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam logic [COUNT_W-1:0] RANGE_COUNT_RESET = COUNT_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_COUNT = 3'd0,
		REG_UP_LO       = 3'd1,
		REG_UP_HI       = 3'd2,
		REG_DN_LO       = 3'd3,
		REG_DN_HI       = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] rising;
		logic [IDX_W-1:0] falling;
	} cand_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// first slot in 1..n-1 with x below its threshold, minus one; else n-1
	function automatic logic [IDX_W-1:0] find_cand(
		input logic signed [THR_W-1:0] x,
		input logic [TABLE_W-1:0]      tbl,
		input logic [COUNT_W-1:0]      n
	);
		logic [IDX_W-1:0] c;
		logic             found;
		found = 1'b0;
		c = IDX_W'(n - COUNT_W'(1));
		for (int i = 1; i < NUM_SLOTS; i++) begin
			if (!found && (COUNT_W'(i) < n) && (x < $signed(tbl[THR_W*i +: THR_W]))) begin
				c = IDX_W'(i - 1);
				found = 1'b1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/hrq_classify.sv
// hrq_classify: configuration registers and the front end that compares
// each sample against both threshold tables. Depends on hrq_pkg.
module hrq_classify import hrq_pkg::*; #(
	parameter int MAX_RANGES  = DEF_MAX_RANGES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample,
	output cand_t                      cand
);

	localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

	logic [COUNT_W-1:0]      range_count_q;
	logic [HALF_W-1:0]       up_lo_q, up_hi_q, dn_lo_q, dn_hi_q;
	logic [COUNT_W-1:0]      n_eff;
	logic signed [THR_W-1:0] x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q <= RANGE_COUNT_RESET;
			up_lo_q <= '0;
			up_hi_q <= '0;
			dn_lo_q <= '0;
			dn_hi_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RANGE_COUNT: range_count_q <= cfg_data[COUNT_W-1:0];
				REG_UP_LO:       up_lo_q <= cfg_data;
				REG_UP_HI:       up_hi_q <= cfg_data;
				REG_DN_LO:       dn_lo_q <= cfg_data;
				REG_DN_HI:       dn_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (range_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (range_count_q > COUNT_W'(MAX_RANGES)) begin
			n_eff = COUNT_W'(MAX_RANGES);
		end else begin
			n_eff = range_count_q;
		end
	end

	// sign extend from the configured sample width
	assign x = $signed(sample << SHIFT) >>> SHIFT;

	assign cand.rising  = find_cand(x, {up_hi_q, up_lo_q}, n_eff);
	assign cand.falling = find_cand(x, {dn_hi_q, dn_lo_q}, n_eff);

endmodule

>>> hdl/hrq_queue.sv
// hrq_queue: short queue of candidate pairs between the front end and
// the hysteresis stage. Depends on hrq_pkg.
module hrq_queue import hrq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cand_t         wr_data,
	input  logic          pop,
	output cand_t         rd_data,
	output queue_status_t status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cand_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty)) else $error("pop from empty queue");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not advance");

endmodule

>>> hdl/hrq_resolve.sv
// hrq_resolve: back end that applies hysteresis to the kept range index
// and holds the output register. Depends on hrq_pkg.
module hrq_resolve import hrq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cand_t            head,
	input  queue_status_t    status,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] range_index,
	output logic [IDX_W-1:0] rising_candidate,
	output logic [IDX_W-1:0] falling_candidate
);

	logic             out_valid_q;
	logic [IDX_W-1:0] current_range_q;
	logic [IDX_W-1:0] next_range;
	logic [IDX_W-1:0] lowered;
	logic [IDX_W-1:0] range_index_q, rising_q, falling_q;

	assign pop = !status.empty && (!out_valid_q || !out_stall);

	always_comb begin
		lowered = (head.falling < current_range_q) ? head.falling : current_range_q;
		if (head.rising == head.falling) begin
			next_range = head.rising;
		end else begin
			next_range = (head.rising > lowered) ? head.rising : lowered;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			current_range_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q     <= 1'b1;
				current_range_q <= next_range;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			range_index_q <= next_range;
			rising_q      <= head.rising;
			falling_q     <= head.falling;
		end
	end

	assign out_valid         = out_valid_q;
	assign range_index       = range_index_q;
	assign rising_candidate  = rising_q;
	assign falling_candidate = falling_q;

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q) else $error("popped item not presented");
	a_kept_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (range_index_q == current_range_q)) else $error("kept index mismatch");
	a_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.rising == head.falling) |=> (current_range_q == $past(head.rising)))
		else $error("agreeing candidates not taken");

endmodule

>>> hdl/hysteresis_range_quantizer.sv
// An accepted sample is compared and its candidates queued; when popped,
// hysteresis is applied into the output register. The two-entry queue
// absorbs output stalls. Throughput: one item per cycle unless in_stall.
// Reset: asynchronous, active low; kept index 0, range count 8, thresholds 0.
// Depends on hrq_pkg, hrq_classify, hrq_queue, hrq_resolve.
module hysteresis_range_quantizer import hrq_pkg::*; #(
	parameter int MAX_RANGES  = DEF_MAX_RANGES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [IDX_W-1:0]           range_index,
	output logic [IDX_W-1:0]           rising_candidate,
	output logic [IDX_W-1:0]           falling_candidate
);

	cand_t         cand, head;
	queue_status_t status;
	logic          push, pop;

	assign in_stall = status.full;
	assign push     = in_valid && !status.full;

	hrq_classify #(
		.MAX_RANGES (MAX_RANGES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample),
		.cand     (cand)
	);

	hrq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(cand),
		.pop    (pop),
		.rd_data(head),
		.status (status)
	);

	hrq_resolve u_resolve (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.status           (status),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.range_index      (range_index),
		.rising_candidate (rising_candidate),
		.falling_candidate(falling_candidate)
	);

endmodule
